>>> rtl/rco_pkg.sv
// ----------------------------------------------------------------------------
// rco_pkg
// Shared widths, codes and sequencer states of the rod cutting optimizer.
// ----------------------------------------------------------------------------
`default_nettype none

package rco_pkg;

  // Field widths
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned PRICE_W = 16;
  localparam int unsigned REV_W   = 22;

  // Default longest rod / piece length
  localparam int unsigned DEF_MAX_LEN = 32;

  // Input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SOLVE = 1'b1;

  // Result kind codes
  localparam logic KIND_REV = 1'b0;
  localparam logic KIND_CUT = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_WAIT,
    ST_REV,
    ST_CUT_RD,
    ST_CUT_DAT
  } rco_state_t;

endpackage : rco_pkg

`default_nettype wire

>>> rtl/rco_ram.sv
// ----------------------------------------------------------------------------
// rco_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rco_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : rco_ram

`default_nettype wire

>>> rtl/rco_ctrl.sv
// ----------------------------------------------------------------------------
// rco_ctrl
// Table-fill and cut-walk sequencer: reads price and revenue entries, keeps
// the running maximum, writes each row back and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rco_ctrl #(
  parameter int unsigned MAX_LEN = rco_pkg::DEF_MAX_LEN,
  parameter int unsigned LW      = $clog2(MAX_LEN + 1),
  parameter int unsigned AW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Input channel (control part)
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_func,
  input  wire logic [rco_pkg::LEN_W-1:0]  in_rod_length,
  // Result channel
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic [rco_pkg::REV_W-1:0]       out_value,
  output logic                            out_last,
  // Price memory read port
  output logic [AW-1:0]                   pr_raddr,
  input  wire logic [rco_pkg::PRICE_W-1:0] pr_rdata,
  // Revenue and first-cut memories
  output logic [AW-1:0]                   rv_raddr,
  input  wire logic [rco_pkg::REV_W-1:0]  rv_rdata,
  output logic                            row_we,
  output logic [AW-1:0]                   row_waddr,
  output logic [rco_pkg::REV_W-1:0]       rv_wdata,
  output logic [LW-1:0]                   ct_wdata,
  output logic [AW-1:0]                   ct_raddr,
  input  wire logic [LW-1:0]              ct_rdata
);

  import rco_pkg::*;

  rco_state_t state_r, state_nxt;

  logic [LW-1:0]    len_r,  len_nxt;
  logic [LW-1:0]    j_r,    j_nxt;
  logic [LW-1:0]    i_r,    i_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [LW-1:0]    rd_i_r, rd_i_nxt;
  logic [REV_W-1:0] best_r, best_nxt;
  logic [LW-1:0]    cut_r,  cut_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r,  out_kind_nxt;
  logic [REV_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r,  out_last_nxt;

  logic [LW-1:0]    len_sat;
  logic [REV_W-1:0] rv_term;
  logic [REV_W:0]   sum;
  logic [REV_W-1:0] cand;
  logic             take;
  logic [REV_W-1:0] best_upd;
  logic [LW-1:0]    cut_upd;
  logic [LW-1:0]    cut_v;
  logic             out_free;
  logic [LW-1:0]    rv_idx;
  logic [LW-1:0]    j_m1;
  logic [LW-1:0]    i_m1;

  // Clamp the requested rod length to the table size
  assign len_sat = (in_rod_length > LEN_W'(MAX_LEN)) ? LW'(MAX_LEN)
                                                     : in_rod_length[LW-1:0];

  // Memory addresses: entry n lives at address n-1
  assign i_m1     = i_r - LW'(1);
  assign j_m1     = j_r - LW'(1);
  assign rv_idx   = j_r - i_r - LW'(1);
  assign pr_raddr = i_m1[AW-1:0];
  assign rv_raddr = rv_idx[AW-1:0];
  assign ct_raddr = j_m1[AW-1:0];

  // Candidate revenue for cut rd_i_r; the remaining length zero adds nothing
  assign rv_term  = (rd_i_r == j_r) ? '0 : rv_rdata;
  assign sum      = {{(REV_W + 1 - PRICE_W){1'b0}}, pr_rdata} + {1'b0, rv_term};
  assign cand     = sum[REV_W-1:0];
  assign take     = (rd_i_r == LW'(1)) || (cand > best_r);
  assign best_upd = take ? cand : best_r;
  assign cut_upd  = take ? rd_i_r : cut_r;

  // Write the finished row while the last candidate is compared
  assign row_we    = rd_vld_r && (state_r == ST_WAIT);
  assign row_waddr = j_m1[AW-1:0];
  assign rv_wdata  = best_upd;
  assign ct_wdata  = cut_upd;

  // Guard the walk against a cut that would overrun the remaining length
  assign cut_v = ((ct_rdata == '0) || (ct_rdata > j_r)) ? j_r : ct_rdata;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    rd_vld_nxt    = 1'b0;
    rd_i_nxt      = rd_i_r;
    best_nxt      = best_r;
    cut_nxt       = cut_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;

    // Fold the candidate read last cycle into the running maximum
    if (rd_vld_r) begin
      best_nxt = best_upd;
      cut_nxt  = cut_upd;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && (in_func == FUNC_SOLVE)) begin
          len_nxt = len_sat;
          j_nxt   = LW'(1);
          i_nxt   = LW'(1);
          if (len_sat == '0) begin
            best_nxt  = '0;
            state_nxt = ST_REV;
          end else begin
            state_nxt = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        // Issue reads for cut i_r of row j_r
        rd_vld_nxt = 1'b1;
        rd_i_nxt   = i_r;
        if (i_r == j_r) begin
          state_nxt = ST_WAIT;
        end else begin
          i_nxt = i_r + LW'(1);
        end
      end
      ST_WAIT: begin
        if (j_r == len_r) begin
          state_nxt = ST_REV;
        end else begin
          j_nxt     = j_r + LW'(1);
          i_nxt     = LW'(1);
          state_nxt = ST_FILL;
        end
      end
      ST_REV: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REV;
          out_value_nxt = best_r;
          out_last_nxt  = (len_r == '0);
          j_nxt         = len_r;
          state_nxt     = (len_r == '0) ? ST_IDLE : ST_CUT_RD;
        end
      end
      ST_CUT_RD: begin
        state_nxt = ST_CUT_DAT;
      end
      ST_CUT_DAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_CUT;
          out_value_nxt = REV_W'(cut_v);
          out_last_nxt  = (cut_v == j_r);
          j_nxt         = j_r - cut_v;
          state_nxt     = (cut_v == j_r) ? ST_IDLE : ST_CUT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    j_r         <= j_nxt;
    i_r         <= i_nxt;
    rd_i_r      <= rd_i_nxt;
    best_r      <= best_nxt;
    cut_r       <= cut_nxt;
    out_kind_r  <= out_kind_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule : rco_ctrl

`default_nettype wire

>>> rtl/rod_cutting_optimizer_top.sv
// Sequence: a solve of length L first fills the tables row by row (one cut per
// cycle, set by the single read port of each memory), then returns the revenue
// and then each cut piece, reading its first-cut entry before it is sent.
// Throughput: one load per cycle while idle; no new item until a solve is done.
// Reset: synchronous, active low; clears the sequencer and the result valid.
// The memories are not cleared; prices must be loaded before they are used.
// ----------------------------------------------------------------------------
// rod_cutting_optimizer_top
// Bottom-up rod cutting solver with price, revenue and first-cut memories.
// ----------------------------------------------------------------------------
`default_nettype none

module rod_cutting_optimizer_top #(
  parameter int unsigned MAX_LEN = rco_pkg::DEF_MAX_LEN
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_func,
  input  wire logic [rco_pkg::LEN_W-1:0]   in_piece_len,
  input  wire logic [rco_pkg::PRICE_W-1:0] in_piece_price,
  input  wire logic [rco_pkg::LEN_W-1:0]   in_rod_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_kind,
  output logic [rco_pkg::REV_W-1:0]        out_value,
  output logic                             out_last
);

  import rco_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic               pr_we;
  logic [LEN_W-1:0]   pr_widx;
  logic [AW-1:0]      pr_raddr;
  logic [PRICE_W-1:0] pr_rdata;
  logic [AW-1:0]      rv_raddr;
  logic [REV_W-1:0]   rv_rdata;
  logic               row_we;
  logic [AW-1:0]      row_waddr;
  logic [REV_W-1:0]   rv_wdata;
  logic [LW-1:0]      ct_wdata;
  logic [AW-1:0]      ct_raddr;
  logic [LW-1:0]      ct_rdata;

  // Store a price on an accepted load with a length inside the table
  assign pr_widx = in_piece_len - LEN_W'(1);
  assign pr_we   = in_valid && in_ready && (in_func == FUNC_LOAD) &&
                   (in_piece_len != '0) && (in_piece_len <= LEN_W'(MAX_LEN));

  rco_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_price_ram (
    .clk   (clk),
    .we    (pr_we),
    .waddr (pr_widx[AW-1:0]),
    .wdata (in_piece_price),
    .raddr (pr_raddr),
    .rdata (pr_rdata)
  );

  rco_ram #(
    .WIDTH (REV_W),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_rev_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (rv_wdata),
    .raddr (rv_raddr),
    .rdata (rv_rdata)
  );

  rco_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_cut_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (ct_wdata),
    .raddr (ct_raddr),
    .rdata (ct_rdata)
  );

  rco_ctrl #(
    .MAX_LEN (MAX_LEN),
    .LW      (LW),
    .AW      (AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_rod_length (in_rod_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_value     (out_value),
    .out_last      (out_last),
    .pr_raddr      (pr_raddr),
    .pr_rdata      (pr_rdata),
    .rv_raddr      (rv_raddr),
    .rv_rdata      (rv_rdata),
    .row_we        (row_we),
    .row_waddr     (row_waddr),
    .rv_wdata      (rv_wdata),
    .ct_wdata      (ct_wdata),
    .ct_raddr      (ct_raddr),
    .ct_rdata      (ct_rdata)
  );

endmodule : rod_cutting_optimizer_top

`default_nettype wire
